### rtl/core/b64_pkg.sv
package b64_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// One queued job: up to four result words for one input item.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            msg_last;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	function automatic logic [7:0] enc_char(input logic [5:0] s);
		logic [7:0] s8;
		s8 = {2'b00, s};
		if (s < 6'd26)      return s8 + 8'd65;
		else if (s < 6'd52) return s8 + 8'd71;  // 'a' - 26
		else if (s < 6'd62) return s8 - 8'd4;   // '0' - 52
		else if (s == 6'd62) return 8'h2B;
		else                 return 8'h2F;
	endfunction

	function automatic sextet_t dec_char(input logic [7:0] c);
		sextet_t r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r.ok = 1'b1;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h47;  // 'a' - 26
			r.ok = 1'b1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'd4;   // '0' - 52
			r.ok = 1'b1;
		end else if (c == 8'h2B) begin
			d = 8'd62;
			r.ok = 1'b1;
		end else if (c == 8'h2F) begin
			d = 8'd63;
			r.ok = 1'b1;
		end
		r.value = d[5:0];
		return r;
	endfunction

endpackage

### rtl/core/b64_front.sv
module b64_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    byte_value,
	input  logic          has_byte,
	input  logic          is_last,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          direction,
	input  logic          q_full,
	output logic          push,
	output b64_pkg::job_t push_job
);
	import b64_pkg::*;

	logic       dir_q;
	logic [5:0] bits_q;
	logic [2:0] cnt_q;
	logic [1:0] phase_q;
	logic       halt_q;

	logic [5:0] bits_d;
	logic [2:0] cnt_d;
	logic [1:0] phase_d;
	logic       halt_d;
	logic [2:0] n;
	logic [3:0][7:0] slot;
	sextet_t    sx;
	logic       accept;

	assign in_ready  = !q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	always_comb begin
		bits_d  = bits_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		halt_d  = halt_q;
		n       = 3'd0;
		slot    = '0;
		sx      = dec_char(byte_value);
		if (dir_q == DIR_ENCODE) begin
			if (has_byte) begin
				case (cnt_q)
					3'd0: begin
						slot[0] = enc_char(byte_value[7:2]);
						n       = 3'd1;
						bits_d  = {4'b0, byte_value[1:0]};
						cnt_d   = 3'd2;
					end
					3'd2: begin
						slot[0] = enc_char({bits_q[1:0], byte_value[7:4]});
						n       = 3'd1;
						bits_d  = {2'b0, byte_value[3:0]};
						cnt_d   = 3'd4;
					end
					default: begin
						slot[0] = enc_char({bits_q[3:0], byte_value[7:6]});
						slot[1] = enc_char(byte_value[5:0]);
						n       = 3'd2;
						bits_d  = '0;
						cnt_d   = 3'd0;
					end
				endcase
				phase_d = phase_q + n[1:0];
			end
			if (is_last) begin
				// flush leftover bits, zero-filled on the right
				if (cnt_d == 3'd2) begin
					slot[n[1:0]] = enc_char({bits_d[1:0], 4'b0});
					n            = n + 3'd1;
					phase_d      = phase_d + 2'd1;
				end else if (cnt_d == 3'd4) begin
					slot[n[1:0]] = enc_char({bits_d[3:0], 2'b0});
					n            = n + 3'd1;
					phase_d      = phase_d + 2'd1;
				end
				for (int i = 0; i < 3; i++) begin
					if (phase_d != 2'd0 && n < 3'd4) begin
						slot[n[1:0]] = PAD_CHAR;
						n            = n + 3'd1;
						phase_d      = phase_d + 2'd1;
					end
				end
				bits_d  = '0;
				cnt_d   = '0;
				phase_d = '0;
				halt_d  = 1'b0;
			end
		end else begin
			if (has_byte && !halt_q) begin
				if (sx.ok) begin
					case (cnt_q)
						3'd0: begin
							bits_d = sx.value;
							cnt_d  = 3'd6;
						end
						3'd6: begin
							slot[0] = {bits_q, sx.value[5:4]};
							n       = 3'd1;
							bits_d  = {2'b0, sx.value[3:0]};
							cnt_d   = 3'd4;
						end
						3'd4: begin
							slot[0] = {bits_q[3:0], sx.value[5:2]};
							n       = 3'd1;
							bits_d  = {4'b0, sx.value[1:0]};
							cnt_d   = 3'd2;
						end
						default: begin
							slot[0] = {bits_q[1:0], sx.value};
							n       = 3'd1;
							bits_d  = '0;
							cnt_d   = 3'd0;
						end
					endcase
				end else if (byte_value == PAD_CHAR) begin
					halt_d = 1'b1;
				end
			end
			if (is_last) begin
				bits_d  = '0;
				cnt_d   = '0;
				phase_d = '0;
				halt_d  = 1'b0;
			end
		end
	end

	assign push              = accept && (n != 3'd0);
	assign push_job.chars    = slot;
	assign push_job.last_idx = 2'(n - 3'd1);
	assign push_job.msg_last = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_ENCODE;
			bits_q  <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
			halt_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			dir_q   <= direction;
			bits_q  <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
			halt_q  <= 1'b0;
		end else if (accept) begin
			bits_q  <= bits_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			halt_q  <= halt_d;
		end
	end

endmodule

### rtl/core/b64_queue.sv
module b64_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  b64_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output b64_pkg::job_t head_job
);
	import b64_pkg::*;

	job_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)      cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

endmodule

### rtl/core/b64_back.sv
module b64_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  b64_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          message_last
);
	import b64_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       msg_last_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!out_valid_q || out_ready);
	assign at_end = (idx_q == head_job.last_idx);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_job.chars[idx_q];
			run_last_q <= at_end;
			msg_last_q <= at_end && head_job.msg_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;
	assign message_last = msg_last_q;

endmodule

### rtl/core/base64_codec.sv
// Each result word passes through the job queue and then the output register.
// One result word per cycle leaves the output register while out_ready is high;
// encoding gives 4 characters per 3 bytes on long runs, at most 2 per byte that
// is not the last and up to 4 per closing item; decoding at most 1 per item.
// Input is taken every cycle while the four-entry job queue has room.
// Reset (arst_n low, asynchronous) selects encode and clears the bit store,
// character phase, pad halt, queue and output valid flag.
module base64_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       has_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       message_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction
);
	import b64_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.direction  (direction),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	b64_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.message_last (message_last)
	);

endmodule

### rtl/core/b64_checker.sv
module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       message_last,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       direction
);
	logic       mode_q;
	logic [1:0] chars_q;
	logic       out_fire;

	assign out_fire = out_valid && out_ready;

	// track direction and encoded characters per message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			chars_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q  <= direction;
			chars_q <= '0;
		end else if (out_fire) begin
			chars_q <= message_last ? 2'd0 : chars_q + 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(run_last) && $stable(message_last))
		else $error("output word changed while stalled");

	a_msg_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_last |-> run_last)
		else $error("message end word not closing its run");

	a_dec_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q |-> run_last)
		else $error("decode item gave more than one word");

	a_enc_quad: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !mode_q && message_last |-> chars_q == 2'd3)
		else $error("encoded message not a multiple of four characters");

endmodule

bind base64_codec b64_checker u_b64_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.run_last     (run_last),
	.message_last (message_last),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.direction    (direction)
);
